/* rtl/rdq_pkg.sv */
// ----------------------------------------------------------------------------
// rdq_pkg
// Shared constants, types and helpers for the 2x2 RGBA downsampler.
// ----------------------------------------------------------------------------
package rdq_pkg;

    // Source tile edge in pixels
    localparam int TILE_SIZE = 512;
    localparam int HALF_TILE = TILE_SIZE / 2;

    // Widths
    localparam int CNT_W   = $clog2(TILE_SIZE);
    localparam int IDX_W   = $clog2(HALF_TILE);
    localparam int PIX_W   = 32;
    localparam int ADDR_W  = 18;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;
    localparam int REG_IDX_W = 1;

    // Per-lane averaging masks
    localparam logic [PIX_W-1:0] LANE_HIGH_MASK = 32'hFEFE_FEFE;
    localparam logic [PIX_W-1:0] LANE_LOW_MASK  = 32'h0101_0101;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_QUAD_X = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_QUAD_Y = 1'b1;

    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [PIX_W-1:0]  pix_t;
    typedef logic [ADDR_W-1:0] addr_t;

    // Quadrant selection handed from the register block to the datapath
    typedef struct packed {
        logic quad_x;
        logic quad_y;
    } cfg_t;

    // floor((p+q)/2) on each of the four 8-bit lanes
    function automatic pix_t lane_mean(input pix_t p, input pix_t q);
        return ((p & LANE_HIGH_MASK) >> 1) + ((q & LANE_HIGH_MASK) >> 1)
             + (p & q & LANE_LOW_MASK);
    endfunction

endpackage

/* rtl/rdq_line_buffer.sv */
// ----------------------------------------------------------------------------
// rdq_line_buffer
// Single-port-write, single-port-read line store holding the horizontal
// pair averages of the last even row. Read data is registered.
// ----------------------------------------------------------------------------
module rdq_line_buffer (
    input  logic          aclk,
    input  logic          wr_en,
    input  rdq_pkg::idx_t wr_addr,
    input  rdq_pkg::pix_t wr_data,
    input  logic          rd_en,
    input  rdq_pkg::idx_t rd_addr,
    output rdq_pkg::pix_t rd_data
);
    import rdq_pkg::*;

    pix_t mem [HALF_TILE];
    pix_t rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/rdq_apb_regs.sv */
// ----------------------------------------------------------------------------
// rdq_apb_regs
// APB register block: quadrant_x at 0x0, quadrant_y at 0x4.
// ----------------------------------------------------------------------------
module rdq_apb_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rdq_pkg::APB_AW-1:0] paddr,
    input  logic [rdq_pkg::APB_DW-1:0] pwdata,
    output logic [rdq_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output rdq_pkg::cfg_t              cfg
);
    import rdq_pkg::*;

    logic                 quad_x_reg;
    logic                 quad_y_reg;
    logic                 wr_stb;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_stb  = psel & penable & pwrite;
    assign reg_idx = paddr[2 +: REG_IDX_W];

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quad_x_reg <= 1'b0;
            quad_y_reg <= 1'b0;
        end else if (wr_stb) begin
            unique case (reg_idx)
                REG_QUAD_X: quad_x_reg <= pwdata[0];
                REG_QUAD_Y: quad_y_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_QUAD_X: prdata[0] = quad_x_reg;
            REG_QUAD_Y: prdata[0] = quad_y_reg;
            default: ;
        endcase
    end

    assign cfg.quad_x = quad_x_reg;
    assign cfg.quad_y = quad_y_reg;

endmodule

/* rtl/rgba_2x2_downsample_quadrant.sv */
// ----------------------------------------------------------------------------
// rgba_2x2_downsample_quadrant
// 2x2 box-filter downsampler for a square tile of packed RGBA words.
// ----------------------------------------------------------------------------
// Usage:
//   Source words enter on s_* (valid/ready) in raster order, TILE_SIZE words
//   per row, TILE_SIZE rows per tile. Each byte lane is averaged on its own.
//   On even rows each horizontal pair average goes to the line buffer; on odd
//   rows the pair average is combined with the stored one and a word leaves
//   on m_* together with its output-buffer address (placed in the quadrant
//   set over APB) and a last flag on the final word of the tile.
//   Throughput: one source word per clock while s_ready is high. A result
//   for an odd-row, odd-column word reaches m_* via stage 1 and the output
//   register: the line buffer read and pair average are registered at the
//   accepting edge, and the final average enters the output register as stage 1 advances.
//   Stalls: when m_ready is low a full output register and the one stage
//   behind it hold; s_ready drops only once both are full.
//   Reset (aresetn low, synchronous) clears the counters, quadrant registers
//   and the pipeline valids. The line buffer needs no clearing: every odd row
//   reads entries written by the even row before it.
// ----------------------------------------------------------------------------
module rgba_2x2_downsample_quadrant (
    input  logic                       aclk,
    input  logic                       aresetn,
    // source words
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [31:0]                s_source_pixel,
    // result words
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [17:0]                m_out_address,
    output logic [31:0]                m_out_pixel,
    output logic                       m_last_pixel,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rdq_pkg::APB_AW-1:0] paddr,
    input  logic [rdq_pkg::APB_DW-1:0] pwdata,
    output logic [rdq_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import rdq_pkg::*;

    cfg_t  cfg;

    cnt_t  col_reg, col_next;
    cnt_t  row_reg, row_next;
    pix_t  held_left_reg;

    logic  s1_valid_reg;
    pix_t  s1_pair_reg;
    addr_t s1_addr_reg;
    logic  s1_last_reg;

    logic  m_valid_reg;
    pix_t  m_pixel_reg;
    addr_t m_addr_reg;
    logic  m_last_reg;

    logic  accept;
    logic  out_adv;
    logic  s1_adv;
    logic  odd_col;
    logic  odd_row;
    logic  emit;
    pix_t  pair;
    idx_t  slot;
    cnt_t  orow;
    cnt_t  ocol;
    addr_t addr;
    pix_t  lb_rd_data;

    rdq_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Handshake: output register frees when empty or taken
    assign out_adv = !m_valid_reg || m_ready;
    assign s1_adv  = s1_valid_reg && out_adv;
    assign s_ready = !s1_valid_reg || out_adv;
    assign accept  = s_valid && s_ready;

    // Position decode and pair average
    assign odd_col = col_reg[0];
    assign odd_row = row_reg[0];
    assign emit    = accept && odd_col && odd_row;
    assign pair    = lane_mean(held_left_reg, s_source_pixel);
    assign slot    = col_reg[1 +: IDX_W];

    // Output address in the double-width buffer
    assign orow = CNT_W'(cfg.quad_y ? HALF_TILE : 0) + CNT_W'(row_reg >> 1);
    assign ocol = CNT_W'(cfg.quad_x ? HALF_TILE : 0) + CNT_W'(col_reg >> 1);
    assign addr = ADDR_W'(ADDR_W'(orow) * ADDR_W'(TILE_SIZE)) + ADDR_W'(ocol);

    // Line buffer: written on even rows, read on odd rows
    rdq_line_buffer u_line_buffer (
        .aclk    (aclk),
        .wr_en   (accept && odd_col && !odd_row),
        .wr_addr (slot),
        .wr_data (pair),
        .rd_en   (emit),
        .rd_addr (slot),
        .rd_data (lb_rd_data)
    );

    // Raster counters
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (col_reg == CNT_W'(TILE_SIZE - 1)) begin
                col_next = '0;
                row_next = (row_reg == CNT_W'(TILE_SIZE - 1)) ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            held_left_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (accept && !odd_col) begin
                held_left_reg <= s_source_pixel;
            end
        end
    end

    // Stage 1: waits for the line buffer read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            s1_pair_reg <= pair;
            s1_addr_reg <= addr;
            s1_last_reg <= (row_reg == CNT_W'(TILE_SIZE - 1))
                        && (col_reg == CNT_W'(TILE_SIZE - 1));
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_adv) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_pixel_reg <= lane_mean(lb_rd_data, s1_pair_reg);
            m_addr_reg  <= s1_addr_reg;
            m_last_reg  <= s1_last_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_address = m_addr_reg;
    assign m_out_pixel   = m_pixel_reg;
    assign m_last_pixel  = m_last_reg;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 2x2 RGBA tile downsampler.
// A clocked driver feeds source words from a queue in random bursts. A clocked
// monitor checks each result word against a bench-side model of the tile walk,
// the line buffer and the quadrant placement. Quadrant registers are changed
// over APB between phases, several times while the first odd row is
// producing results.
// ----------------------------------------------------------------------------
module tb;

    import rdq_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int RST_CYCLES  = 5;
    localparam int DRAIN_WAIT  = 8;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int MAX_PRINTS  = 40;

    typedef logic [APB_AW-1:0] paddr_t;

    typedef struct {
        addr_t addr;
        pix_t  pix;
        logic  last;
    } shrunk_word_t;

    // clock, reset and block ports
    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    pix_t         s_source_pixel = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [17:0]  m_out_address;
    logic [31:0]  m_out_pixel;
    logic         m_last_pixel;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    paddr_t       paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic         pready;

    // stimulus and expectations
    pix_t         source_words_q[$];
    shrunk_word_t shrunk_words_q[$];
    int           fail_count = 0;
    int           cycle_count = 0;

    // model state: tile position, held left word, even-row pair averages
    int unsigned  col_pos = 0;
    int unsigned  row_pos = 0;
    pix_t         left_px = '0;
    pix_t         pair_row[HALF_TILE];
    logic         qx_cfg = 1'b0;
    logic         qy_cfg = 1'b0;

    // generator position, used to place the directed words
    int unsigned  gen_col = 0;
    int unsigned  gen_row = 0;
    int unsigned  gen_tile = 0;

    // sender burst shaping and receiver stall pattern
    int           burst_left = 0;
    int           gap_left = 0;
    int           stall_mode = 0;
    int           stall_left = 0;
    int           stall_tick = 0;

    rgba_2x2_downsample_quadrant DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_source_pixel (s_source_pixel),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_address  (m_out_address),
        .m_out_pixel    (m_out_pixel),
        .m_last_pixel   (m_last_pixel),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // one line per mismatch, printing capped to keep the log short
    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // floor((a+b)/2) on each byte lane
    function automatic pix_t lane_avg(input pix_t a, input pix_t b);
        pix_t       r;
        logic [8:0] s;
        for (int l = 0; l < 4; l++) begin
            s = a[8*l +: 8] + b[8*l +: 8];
            r[8*l +: 8] = s[8:1];
        end
        return r;
    endfunction

    // advance the model by one accepted source word
    function automatic void shrink_accept(input pix_t px);
        pix_t         pair;
        shrunk_word_t w;
        int unsigned  orow;
        int unsigned  ocol;
        if ((col_pos & 1) == 0) begin
            left_px = px;
        end else begin
            pair = lane_avg(left_px, px);
            if ((row_pos & 1) == 0) begin
                pair_row[col_pos / 2] = pair;
            end else begin
                orow   = (qy_cfg ? HALF_TILE : 0) + row_pos / 2;
                ocol   = (qx_cfg ? HALF_TILE : 0) + col_pos / 2;
                w.addr = addr_t'(orow * TILE_SIZE + ocol);
                w.pix  = lane_avg(pair_row[col_pos / 2], pair);
                w.last = (row_pos == TILE_SIZE - 1) && (col_pos == TILE_SIZE - 1);
                shrunk_words_q.push_back(w);
            end
        end
        col_pos++;
        if (col_pos >= TILE_SIZE) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= TILE_SIZE) begin
                row_pos = 0;
            end
        end
    endfunction

    // next source word: directed corner values at the head of the first two
    // rows, otherwise random words with lane extremes mixed in
    function automatic pix_t make_pixel();
        pix_t        px;
        int unsigned k;
        if (gen_tile == 0 && gen_row < 2 && gen_col < 24) begin
            k = (gen_row == 0) ? gen_col : 23 - gen_col;
            case (k)
                0:       px = 32'h0000_0000;
                1, 2, 3: px = 32'hFFFF_FFFF;
                4, 5:    px = 32'h0000_0000;
                6, 7:    px = 32'h0101_0101;
                8:       px = 32'hFEFE_FEFE;
                9:       px = 32'hFFFF_FFFF;
                10:      px = 32'h8080_8080;
                11:      px = 32'h7F7F_7F7F;
                12:      px = 32'h00FF_00FF;
                13:      px = 32'hFF00_FF00;
                14:      px = 32'h1234_5678;
                15:      px = 32'h8765_4321;
                16:      px = 32'h01FE_01FE;
                17:      px = 32'hFE01_FE01;
                18:      px = 32'hAAAA_AAAA;
                19:      px = 32'h5555_5555;
                20:      px = 32'hFFFF_FFFF;
                21:      px = 32'h0000_0000;
                22:      px = 32'h0000_0001;
                default: px = 32'h8000_0000;
            endcase
        end else if ($urandom_range(0, 3) == 0) begin
            px = $urandom;
        end else begin
            for (int l = 0; l < 4; l++) begin
                case ($urandom_range(0, 9))
                    0:       px[8*l +: 8] = 8'h00;
                    1:       px[8*l +: 8] = 8'h01;
                    2:       px[8*l +: 8] = 8'h7F;
                    3:       px[8*l +: 8] = 8'h80;
                    4:       px[8*l +: 8] = 8'hFE;
                    5:       px[8*l +: 8] = 8'hFF;
                    default: px[8*l +: 8] = 8'($urandom);
                endcase
            end
        end
        gen_col++;
        if (gen_col >= TILE_SIZE) begin
            gen_col = 0;
            gen_row++;
            if (gen_row >= TILE_SIZE) begin
                gen_row = 0;
                gen_tile++;
            end
        end
        return px;
    endfunction

    // APB write then read-back of one quadrant register
    task automatic quad_reg_access(input paddr_t addr, input logic val, output logic rd);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {31'($urandom_range(0, 32'h7FFF_FFFF)), val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rd = prdata[0];
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // set both quadrants, queue a run of source words, wait for all results
    task automatic run_phase(input logic qx, input logic qy, input int count);
        logic rd;
        quad_reg_access(paddr_t'(4 * REG_QUAD_X), qx, rd);
        qx_cfg = qx;
        if (rd !== qx) begin
            report_mismatch($sformatf("quadrant_x read %b want %b", rd, qx));
        end
        quad_reg_access(paddr_t'(4 * REG_QUAD_Y), qy, rd);
        qy_cfg = qy;
        if (rd !== qy) begin
            report_mismatch($sformatf("quadrant_y read %b want %b", rd, qy));
        end
        repeat (count) source_words_q.push_back(make_pixel());
        // checked between edges so that the driver and monitor have settled
        while (source_words_q.size() != 0 || s_valid || shrunk_words_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // source driver: bursts of random length, random gaps, some long runs
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                shrink_accept(s_source_pixel);
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (source_words_q.size() != 0) begin
                    s_valid        <= 1'b1;
                    s_source_pixel <= source_words_q.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end
                    if (burst_left == 0) begin
                        gap_left   = $urandom_range(1, 5);
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 600)
                                                                 : $urandom_range(1, 24);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result stall pattern: a random mode is held for a random stretch, then redrawn
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(50, 600);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            2:       m_ready <= (stall_tick % 7) < 4;
            default: m_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // result monitor: compare each word with the oldest expectation
    always @(posedge aclk) begin
        shrunk_word_t w;
        if (aresetn && m_valid && m_ready) begin
            if (shrunk_words_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word addr %h pix %h",
                                          m_out_address, m_out_pixel));
            end else begin
                w = shrunk_words_q.pop_front();
                if (m_out_address !== w.addr) begin
                    report_mismatch($sformatf("address got %h want %h", m_out_address, w.addr));
                end
                if (m_out_pixel !== w.pix) begin
                    report_mismatch($sformatf("pixel at %h got %h want %h",
                                              w.addr, m_out_pixel, w.pix));
                end
                if (m_last_pixel !== w.last) begin
                    report_mismatch($sformatf("last at %h got %b want %b",
                                              w.addr, m_last_pixel, w.last));
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // test sequence: first even row, then quadrant changes across the odd row
    initial begin
        repeat (RST_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_phase(1'b0, 1'b0, 300);
        run_phase(1'b1, 1'b0, 350);
        run_phase(1'b0, 1'b1, 200);
        run_phase(1'b1, 1'b1, 150);
        run_phase(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 200);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
